>>> rtl/mdc_pkg.sv
// Shared types, constants and the sine table function of the modulated delay chorus.
package mdc_pkg;

  // Default sizes
  localparam int unsigned DelayDepthDef = 131072;
  localparam int unsigned SineSizeDef   = 1024;

  // Fixed-point constants of the tone blend and chorus mix
  localparam int unsigned ChorusDryK = 13763;
  localparam int unsigned ChorusWetK = 25559;
  localparam int unsigned G1Base     = 9830;
  localparam int unsigned G1Span     = 22938;
  localparam int unsigned G2Base     = 22938;
  localparam int unsigned G2Span     = 11469;
  localparam int unsigned UnityQ15   = 32768;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MODE,
    REG_BASE_DELAY,
    REG_MOD_DEPTH,
    REG_PHASE_STEP,
    REG_SPREAD,
    REG_FEEDBACK,
    REG_TONE,
    REG_MIX
  } reg_idx_e;

  typedef enum logic [1:0] {
    MODE_CHORUS,
    MODE_FLANGE,
    MODE_DUB,
    MODE_WIDE
  } mode_e;

  typedef struct packed {
    mode_e       mode;
    logic [24:0] base_delay;
    logic [19:0] mod_depth;
    logic [31:0] phase_step;
    logic [31:0] spread_offset;
    logic [14:0] feedback;
    logic [31:0] tone_setting;
    logic [31:0] mix_gains;
  } cfg_t;

  // Sequencer steps; the per-channel steps run LFO through MIX
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_GAIN1,
    ST_GAIN2,
    ST_GAIN3,
    ST_LFO,
    ST_MOD,
    ST_DELAY,
    ST_ADDR,
    ST_RD_A,
    ST_RD_B,
    ST_TAP_B,
    ST_INTERP,
    ST_D,
    ST_TONE,
    ST_FILT,
    ST_PD,
    ST_PS,
    ST_P,
    ST_FB,
    ST_WRITE,
    ST_WD,
    ST_WET,
    ST_MD,
    ST_MW,
    ST_MIX,
    ST_FIN
  } state_e;

  typedef struct packed {
    state_e step;
    logic   ch;
    logic   accept;
    logic   load_out;
  } cmd_t;

  // Sine table entry k of a table with 2^tw entries, Q1.15
  function automatic logic signed [15:0] sine_entry(input int unsigned k,
                                                    input int unsigned tw);
    logic [31:0] p;
    logic [31:0] x;
    logic [31:0] x2;
    logic [31:0] t;
    logic [31:0] y;
    logic [1:0]  q;
    p = 32'(k) << (32 - tw);
    q = p[31:30];
    x = {17'd0, p[29:15]};
    if (q[0]) x = 32'd32768 - x;
    x2 = (x * x) >> 15;
    t = ((32'd21024 - ((32'd2320 * x2) >> 15)) * x2) >> 15;
    t = 32'd51472 - t;
    y = (t * x) >> 15;
    if (y > 32'd32767) y = 32'd32767;
    return q[1] ? 16'(32'd0 - y) : 16'(y);
  endfunction

endpackage

>>> rtl/modulated_delay_chorus.sv
// Top level of the stereo modulated delay chorus / flanger.
//
// One stereo frame of Q1.15 samples goes in, one stereo frame comes out. A frame runs
// through 3 shared gain steps, then 21 steps per channel, then the result load, and no
// new frame is taken before the sequencer is back in idle; the pace is set by the single
// shared multiplier, which the sequencer steps through each product in turn, and by the
// one read port of each delay line (the two taps of the interpolation are read in
// consecutive cycles). The input side is free again while a finished result still waits
// in the output register. The delay lines need no clearing pass after reset: a fill flag
// and the write position mark which entries have been written, and the rest read as zero.
// DELAY_DEPTH and SINE_TABLE_SIZE must be powers of two; the block does not check this.
// Configuration writes are taken in any cycle and belong to times when the block is idle.
module modulated_delay_chorus #(
  parameter int unsigned DELAY_DEPTH     = mdc_pkg::DelayDepthDef,
  parameter int unsigned SINE_TABLE_SIZE = mdc_pkg::SineSizeDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [15:0]           left_sample_i,
  input  logic signed [15:0]           right_sample_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [15:0]           left_out_o,
  output logic signed [15:0]           right_out_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [mdc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [mdc_pkg::CfgDataW-1:0] cfg_data_i
);
  import mdc_pkg::*;

  cfg_t cfg;
  cmd_t cmd;

  mdc_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  mdc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  mdc_dp #(
    .DelayDepth (DELAY_DEPTH),
    .SineSize   (SINE_TABLE_SIZE)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .cfg_i          (cfg),
    .left_sample_i  (left_sample_i),
    .right_sample_i (right_sample_i),
    .left_out_o     (left_out_o),
    .right_out_o    (right_out_o)
  );

endmodule

>>> rtl/mdc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module mdc_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/mdc_regs.sv
// Configuration register file of the modulated delay chorus.
module mdc_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [mdc_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [mdc_pkg::CfgDataW-1:0]   cfg_data_i,
  output mdc_pkg::cfg_t                  cfg_o
);
  import mdc_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;

  assign cfg_ready_o = 1'b1;

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_MODE:       cfg_d.mode          = mode_e'(cfg_data_i[1:0]);
        REG_BASE_DELAY: cfg_d.base_delay    = cfg_data_i[24:0];
        REG_MOD_DEPTH:  cfg_d.mod_depth     = cfg_data_i[19:0];
        REG_PHASE_STEP: cfg_d.phase_step    = cfg_data_i;
        REG_SPREAD:     cfg_d.spread_offset = cfg_data_i;
        REG_FEEDBACK:   cfg_d.feedback      = cfg_data_i[14:0];
        REG_TONE:       cfg_d.tone_setting  = cfg_data_i;
        REG_MIX:        cfg_d.mix_gains     = cfg_data_i;
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode          <= MODE_CHORUS;
      cfg_q.base_delay    <= 25'd516096;
      cfg_q.mod_depth     <= '0;
      cfg_q.phase_step    <= '0;
      cfg_q.spread_offset <= '0;
      cfg_q.feedback      <= 15'd8847;
      cfg_q.tone_setting  <= '0;
      cfg_q.mix_gains     <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/mdc_ctrl.sv
// Step sequencer and handshake control of the modulated delay chorus.
module mdc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output mdc_pkg::cmd_t cmd_o
);
  import mdc_pkg::*;

  state_e state_q, state_d;
  logic   ch_q, ch_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    ch_d    = ch_q;
    case (state_q)
      ST_IDLE: begin
        ch_d = 1'b0;
        if (in_valid_i) state_d = ST_GAIN1;
      end
      ST_GAIN1:  state_d = ST_GAIN2;
      ST_GAIN2:  state_d = ST_GAIN3;
      ST_GAIN3:  state_d = ST_LFO;
      ST_LFO:    state_d = ST_MOD;
      ST_MOD:    state_d = ST_DELAY;
      ST_DELAY:  state_d = ST_ADDR;
      ST_ADDR:   state_d = ST_RD_A;
      ST_RD_A:   state_d = ST_RD_B;
      ST_RD_B:   state_d = ST_TAP_B;
      ST_TAP_B:  state_d = ST_INTERP;
      ST_INTERP: state_d = ST_D;
      ST_D:      state_d = ST_TONE;
      ST_TONE:   state_d = ST_FILT;
      ST_FILT:   state_d = ST_PD;
      ST_PD:     state_d = ST_PS;
      ST_PS:     state_d = ST_P;
      ST_P:      state_d = ST_FB;
      ST_FB:     state_d = ST_WRITE;
      ST_WRITE:  state_d = ST_WD;
      ST_WD:     state_d = ST_WET;
      ST_WET:    state_d = ST_MD;
      ST_MD:     state_d = ST_MW;
      ST_MW:     state_d = ST_MIX;
      ST_MIX: begin
        ch_d    = !ch_q;
        state_d = ch_q ? ST_FIN : ST_LFO;
      end
      ST_FIN: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o.step     = state_q;
    cmd_o.ch       = ch_q;
    cmd_o.accept   = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.load_out = (state_q == ST_FIN) && out_free;
    in_ready_o     = (state_q == ST_IDLE);
    out_valid_o    = out_valid_q;
  end

  // result register holds its item until taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.load_out) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ch_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ch_q        <= ch_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_accept_starts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_GAIN1))
    else $error("accepted item did not start the sequence");

  a_left_first : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_GAIN1) |-> !ch_q)
    else $error("frame did not start on the left channel");

  a_load_sets_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |=> out_valid_q)
    else $error("result load did not raise out_valid");

endmodule

>>> rtl/mdc_dp.sv
// Datapath of the modulated delay chorus: shared multiplier, delay lines, LFO and state.
module mdc_dp #(
  parameter int unsigned DelayDepth = mdc_pkg::DelayDepthDef,
  parameter int unsigned SineSize   = mdc_pkg::SineSizeDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mdc_pkg::cmd_t       cmd_i,
  input  mdc_pkg::cfg_t       cfg_i,
  input  logic signed [15:0]  left_sample_i,
  input  logic signed [15:0]  right_sample_i,
  output logic signed [15:0]  left_out_o,
  output logic signed [15:0]  right_out_o
);
  import mdc_pkg::*;

  localparam int unsigned AW = $clog2(DelayDepth);
  localparam int unsigned TW = $clog2(SineSize);
  localparam int unsigned QS = SineSize / 4;
  localparam int unsigned JW = TW - 1;
  localparam int unsigned PW = (AW + 11 > 28) ? AW + 11 : 28;
  localparam logic signed [PW-1:0] MinDelay = PW'(256);
  localparam logic signed [PW-1:0] MaxDelay = PW'((longint'(DelayDepth) - 4) * 256);
  localparam logic signed [PW-1:0] LineSpan = PW'(longint'(DelayDepth) * 256);

  function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
    if (v > 48'sd32767) return 16'sh7fff;
    if (v < -48'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // quarter-wave sine table; the other quadrants mirror and negate it
  logic signed [15:0] sine_rom [QS];
  for (genvar k = 0; k < QS; k++) begin : g_sine
    assign sine_rom[k] = sine_entry(int'(k), TW);
  end

  // frame state
  logic [AW-1:0]       wp_q;
  logic                wrap_q;
  logic [31:0]         phase_q;
  logic signed [23:0]  s_q [2];

  // working registers
  logic signed [15:0]  dry_q [2];
  logic signed [15:0]  res_q [2];
  logic signed [15:0]  left_out_q, right_out_q;
  logic signed [15:0]  lfo_q;
  logic signed [46:0]  prod_q;
  logic signed [47:0]  acc_q;
  logic [16:0]         g1_q;
  logic [15:0]         g2_q;
  logic signed [PW-1:0] delay_q;
  logic [AW-1:0]       ia_q, ib_q;
  logic [7:0]          f_q;
  logic                va_q, vb_q;
  logic signed [15:0]  a_q, b_q, d_q;
  logic signed [17:0]  p_q;
  logic signed [18:0]  wet_q;

  // per-step combinational values
  logic                ch;
  logic signed [15:0]  dry;
  logic signed [23:0]  s_cur;
  logic [31:0]         phase_c;
  logic [TW-1:0]       lfo_idx;
  logic [JW-1:0]       lfo_j;
  logic signed [15:0]  lfo_c;
  logic [15:0]         tone_v, alpha_v;
  logic signed [25:0]  mul_a;
  logic signed [20:0]  mul_b;
  logic signed [16:0]  tap_diff;
  logic signed [24:0]  tone_diff;
  logic signed [PW-1:0] delay_raw, delay_clamped, pos, pos_w;
  logic [AW-1:0]       ia_c, ib_c;
  logic signed [47:0]  sum;
  logic signed [28:0]  s_new;
  logic signed [23:0]  s_sat;
  logic signed [32:0]  line_sum;
  logic signed [15:0]  line_wdata;
  logic signed [18:0]  wet_c;
  logic [15:0]         rdata_l, rdata_r, rdata;
  logic                we_l, we_r;
  logic [AW-1:0]       raddr;

  assign ch    = cmd_i.ch;
  assign dry   = dry_q[ch];
  assign s_cur = s_q[ch];

  // LFO phase of this channel, and gains clipped at unity
  always_comb begin
    phase_c = ch ? phase_q + cfg_i.spread_offset : phase_q - cfg_i.spread_offset;
    tone_v  = (cfg_i.tone_setting[31:16] > 16'(UnityQ15)) ? 16'(UnityQ15)
                                                         : cfg_i.tone_setting[31:16];
    alpha_v = (cfg_i.tone_setting[15:0] > 16'(UnityQ15)) ? 16'(UnityQ15)
                                                        : cfg_i.tone_setting[15:0];
    tap_diff  = 17'(b_q) - 17'(a_q);
    tone_diff = 25'($signed({d_q, 8'd0})) - 25'(s_cur);
  end

  // sine lookup: odd quadrants run the quarter backwards, the upper half negates
  always_comb begin
    lfo_idx = phase_c[31 -: TW];
    lfo_j   = {1'b0, lfo_idx[TW-3:0]};
    if (lfo_idx[TW-2]) lfo_j = JW'(QS) - lfo_j;
    // quarter peak lies one past the end of the table
    if (lfo_j[JW-1]) lfo_c = 16'sh7fff;
    else             lfo_c = sine_rom[lfo_j[TW-3:0]];
    if (lfo_idx[TW-1]) lfo_c = -lfo_c;
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.step)
      ST_GAIN1:  begin mul_a = {10'd0, tone_v}; mul_b = 21'(G1Span); end
      ST_GAIN2:  begin mul_a = {10'd0, tone_v}; mul_b = 21'(G2Span); end
      ST_MOD:    begin mul_a = 26'(lfo_q);     mul_b = {1'b0, cfg_i.mod_depth}; end
      ST_INTERP: begin mul_a = 26'(tap_diff);  mul_b = {13'd0, f_q}; end
      ST_TONE:   begin mul_a = 26'(tone_diff); mul_b = {5'd0, alpha_v}; end
      ST_PD:     begin mul_a = 26'(d_q);       mul_b = {4'd0, g1_q}; end
      ST_PS:     begin mul_a = 26'(s_cur);     mul_b = {5'd0, g2_q}; end
      ST_FB:     begin mul_a = 26'(p_q);       mul_b = {6'd0, cfg_i.feedback}; end
      ST_WRITE:  begin mul_a = 26'(dry);       mul_b = 21'(ChorusDryK); end
      ST_WD:     begin mul_a = 26'(p_q);       mul_b = 21'(ChorusWetK); end
      ST_MD:     begin mul_a = 26'(dry);       mul_b = {5'd0, cfg_i.mix_gains[31:16]}; end
      ST_MW:     begin mul_a = 26'(wet_q);     mul_b = {5'd0, cfg_i.mix_gains[15:0]}; end
      default:   begin mul_a = '0;             mul_b = '0; end
    endcase
  end

  // delay clamp and read position
  always_comb begin
    delay_raw = PW'($signed({1'b0, cfg_i.base_delay})) + PW'($signed(prod_q[46:15]));
    if (delay_raw < MinDelay)      delay_clamped = MinDelay;
    else if (delay_raw > MaxDelay) delay_clamped = MaxDelay;
    else                           delay_clamped = delay_raw;
    pos   = PW'($signed({1'b0, wp_q, 8'd0})) - delay_q;
    pos_w = (pos < 0) ? pos + LineSpan : pos;
    ia_c  = pos_w[AW+7:8];
    ib_c  = ia_c + 1'b1;
  end

  // accumulate, filter, feedback and wet arithmetic
  always_comb begin
    sum        = acc_q + 48'(prod_q);
    s_new      = 29'(s_cur) + 29'($signed(prod_q[42:15]));
    if (s_new > 29'sd8388607)       s_sat = 24'sh7fffff;
    else if (s_new < -29'sd8388608) s_sat = 24'sh800000;
    else                            s_sat = s_new[23:0];
    line_sum   = 33'(dry) + 33'($signed(prod_q[46:15]));
    line_wdata = sat16(48'(line_sum));
    wet_c      = (cfg_i.mode == MODE_CHORUS) ? sum[33:15] : 19'(p_q);
    if (cfg_i.mode == MODE_WIDE && ch) wet_c = -wet_c;
  end

  // delay line ports
  always_comb begin
    raddr = (cmd_i.step == ST_RD_B) ? ib_q : ia_q;
    we_l  = (cmd_i.step == ST_WRITE) && !ch;
    we_r  = (cmd_i.step == ST_WRITE) && ch;
    rdata = ch ? rdata_r : rdata_l;
  end

  mdc_ram #(.Width(16), .Depth(DelayDepth)) u_line_l (
    .clk_i   (clk_i),
    .we_i    (we_l),
    .waddr_i (wp_q),
    .wdata_i (line_wdata),
    .raddr_i (raddr),
    .rdata_o (rdata_l)
  );

  mdc_ram #(.Width(16), .Depth(DelayDepth)) u_line_r (
    .clk_i   (clk_i),
    .we_i    (we_r),
    .waddr_i (wp_q),
    .wdata_i (line_wdata),
    .raddr_i (raddr),
    .rdata_o (rdata_r)
  );

  // frame state: write position, fill flag, LFO phase, tone filters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      wrap_q  <= 1'b0;
      phase_q <= '0;
      s_q[0]  <= '0;
      s_q[1]  <= '0;
    end else begin
      if (cmd_i.step == ST_FILT) s_q[ch] <= s_sat;
      if (cmd_i.load_out) begin
        wp_q    <= wp_q + 1'b1;
        phase_q <= phase_q + cfg_i.phase_step;
        if (wp_q == '1) wrap_q <= 1'b1;
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (cmd_i.accept) begin
      dry_q[0] <= left_sample_i;
      dry_q[1] <= right_sample_i;
    end
    case (cmd_i.step)
      ST_GAIN2: g1_q <= 17'(G1Base) + {1'b0, prod_q[30:15]};
      ST_GAIN3: g2_q <= 16'(G2Base) - prod_q[30:15];
      ST_LFO:   lfo_q <= lfo_c;
      ST_DELAY: delay_q <= delay_clamped;
      ST_ADDR: begin
        ia_q <= ia_c;
        ib_q <= ib_c;
        f_q  <= pos_w[7:0];
        // entries not yet written since reset read as zero
        va_q <= wrap_q || (ia_c < wp_q);
        vb_q <= wrap_q || (ib_c < wp_q);
      end
      ST_RD_B:  a_q <= va_q ? $signed(rdata) : 16'sd0;
      ST_TAP_B: b_q <= vb_q ? $signed(rdata) : 16'sd0;
      ST_D:     d_q <= 16'(17'(a_q) + $signed(prod_q[24:8]));
      ST_PS:    acc_q <= 48'(prod_q) <<< 8;
      ST_P:     p_q <= sum[40:23];
      ST_WD:    acc_q <= 48'(prod_q);
      ST_WET:   wet_q <= wet_c;
      ST_MW:    acc_q <= 48'(prod_q);
      ST_MIX:   res_q[ch] <= sat16(48'($signed(sum[47:14])));
      default:  acc_q <= acc_q;
    endcase
    if (cmd_i.load_out) begin
      left_out_q  <= res_q[0];
      right_out_q <= res_q[1];
    end
  end

  assign left_out_o  = left_out_q;
  assign right_out_o = right_out_q;

endmodule
